FILE: design/bfsp_pkg.sv
// Package for the Bellman-Ford shortest path block: beat types, register
// indexes, controller states and the command/status structs.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package bfsp_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 1'b1;

    localparam logic [6:0] VERTEX_COUNT_RESET  = 7'd1;
    localparam logic [5:0] SOURCE_VERTEX_RESET = 6'd0;

    typedef struct packed {
        logic [5:0]         from_vertex;
        logic [5:0]         to_vertex;
        logic signed [31:0] edge_weight;
        logic               last_edge;
    } in_beat_t;

    typedef struct packed {
        logic [5:0]         vertex_index;
        logic signed [47:0] distance;
        logic               reachable;
        logic               negative_cycle;
        logic               edges_dropped;
        logic               last_result;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_RELAX,
        ST_PASS_END,
        ST_OUT_RD,
        ST_OUT_SHOW
    } bfsp_state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic edge_rd;
        logic dist_rd;
        logic relax;
        logic advance;
        logic pass_next;
        logic set_cycle;
        logic out_rd;
        logic out_next;
        logic clear;
    } bfsp_cmd_t;

    typedef struct packed {
        logic last_in;
        logic skip;
        logic edge_match;
        logic scan_end;
        logic changed;
        logic iter_last;
        logic k_last;
    } bfsp_status_t;

endpackage

FILE: design/bfsp_ctrl.sv
// Controller state machine of the Bellman-Ford block: sequences loading,
// relaxation passes and result output. Depends on bfsp_pkg.
`timescale 1ns / 1ps

module bfsp_ctrl import bfsp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  bfsp_status_t status,
    output bfsp_cmd_t    cmd
);

    bfsp_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && status.last_in) state_next = ST_INIT;
            end
            ST_INIT: begin
                state_next = status.skip ? ST_OUT_RD : ST_EDGE_RD;
            end
            ST_EDGE_RD: begin
                state_next = ST_EDGE_CHK;
            end
            ST_EDGE_CHK: begin
                if (status.edge_match) state_next = ST_RELAX;
                else state_next = status.scan_end ? ST_PASS_END : ST_EDGE_RD;
            end
            ST_RELAX: begin
                state_next = status.scan_end ? ST_PASS_END : ST_EDGE_RD;
            end
            ST_PASS_END: begin
                if (!status.changed || status.iter_last) state_next = ST_OUT_RD;
                else state_next = ST_EDGE_RD;
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_SHOW;
            end
            ST_OUT_SHOW: begin
                if (m_ready) state_next = status.k_last ? ST_LOAD : ST_OUT_RD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_INIT: begin
                cmd.init = 1'b1;
            end
            ST_EDGE_RD: begin
                cmd.edge_rd = 1'b1;
            end
            ST_EDGE_CHK: begin
                if (status.edge_match) cmd.dist_rd = 1'b1;
                else cmd.advance = 1'b1;
            end
            ST_RELAX: begin
                cmd.relax   = 1'b1;
                cmd.advance = 1'b1;
            end
            ST_PASS_END: begin
                if (status.changed) begin
                    if (status.iter_last) cmd.set_cycle = 1'b1;
                    else cmd.pass_next = 1'b1;
                end
            end
            ST_OUT_RD: begin
                cmd.out_rd = 1'b1;
            end
            ST_OUT_SHOW: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.k_last) cmd.clear = 1'b1;
                    else cmd.out_next = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: design/bfsp_datapath.sv
// Datapath of the Bellman-Ford block: configuration registers, edge memory,
// distance memory, reach bits, scan counters and the relaxation adder.
// Depends on bfsp_pkg; driven by bfsp_ctrl through bfsp_cmd_t.
`timescale 1ns / 1ps

module bfsp_datapath import bfsp_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_beat_t              s_data,
    input  bfsp_cmd_t             cmd,
    output bfsp_status_t          status,
    output out_beat_t             m_data
);

    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
    localparam int EIDX_W = $clog2(MAX_EDGES);
    localparam int ETOT_W = $clog2(MAX_EDGES + 1);
    // Room for the longest chain of relaxations over all passes.
    localparam int ACC_W  = WEIGHT_BITS + VIDX_W + EIDX_W + 2;
    localparam int EDGE_W = 2 * VIDX_W + WEIGHT_BITS;

    // Configuration.
    logic [6:0] vcount_reg;
    logic [5:0] source_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VERTEX_COUNT_RESET;
            source_reg <= SOURCE_VERTEX_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT:  vcount_reg <= cfg_data[6:0];
                CFG_SOURCE_VERTEX: source_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Effective vertex count, clamped to the supported range.
    logic [VCNT_W-1:0] n_eff;
    always_comb begin
        if (vcount_reg == 7'd0) n_eff = VCNT_W'(1);
        else if (vcount_reg > 7'(MAX_VERTICES)) n_eff = VCNT_W'(MAX_VERTICES);
        else n_eff = VCNT_W'(vcount_reg);
    end

    logic              source_ok;
    logic [VIDX_W-1:0] source_idx;
    assign source_ok  = 7'(source_reg) < 7'(n_eff);
    assign source_idx = VIDX_W'(source_reg);

    // Edge loading.
    logic [ETOT_W-1:0]      edge_total_reg;
    logic                   dropped_reg;
    logic [EDGE_W-1:0]      edge_mem [MAX_EDGES];
    logic [EDGE_W-1:0]      edge_q_reg;
    logic                   load_drop;
    logic [WEIGHT_BITS-1:0] load_weight;
    logic [EIDX_W-1:0]      e_reg;

    assign load_drop = (7'(s_data.from_vertex) >= 7'(n_eff))
                    || (7'(s_data.to_vertex) >= 7'(n_eff))
                    || (edge_total_reg == ETOT_W'(MAX_EDGES));
    assign load_weight = WEIGHT_BITS'(unsigned'(s_data.edge_weight));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_total_reg <= '0;
            dropped_reg    <= 1'b0;
        end else if (cmd.load) begin
            if (load_drop) dropped_reg <= 1'b1;
            else edge_total_reg <= edge_total_reg + ETOT_W'(1);
        end else if (cmd.clear) begin
            edge_total_reg <= '0;
            dropped_reg    <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && !load_drop) begin
            edge_mem[edge_total_reg[EIDX_W-1:0]] <= {VIDX_W'(s_data.from_vertex),
                                                     VIDX_W'(s_data.to_vertex),
                                                     load_weight};
        end
        if (cmd.edge_rd) edge_q_reg <= edge_mem[e_reg];
    end

    logic [VIDX_W-1:0]             from_q, to_q;
    logic signed [WEIGHT_BITS-1:0] weight_q;
    assign from_q   = edge_q_reg[EDGE_W-1 -: VIDX_W];
    assign to_q     = edge_q_reg[VIDX_W+WEIGHT_BITS-1 -: VIDX_W];
    assign weight_q = signed'(edge_q_reg[WEIGHT_BITS-1:0]);

    // Scan counters and pass flags.
    logic [VIDX_W-1:0] v_reg, iter_reg, k_reg;
    logic              changed_reg, cycle_reg;
    logic [MAX_VERTICES-1:0] reach_reg;
    logic signed [ACC_W-1:0] dist_a_reg, dist_b_reg, cand;
    logic              update, e_last, v_last;

    assign e_last = (ETOT_W'(e_reg) + ETOT_W'(1)) == edge_total_reg;
    assign v_last = (VCNT_W'(v_reg) + VCNT_W'(1)) == n_eff;
    assign cand   = dist_a_reg + ACC_W'(weight_q);
    assign update = !reach_reg[to_q] || (dist_b_reg > cand);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            e_reg       <= '0;
            iter_reg    <= '0;
            k_reg       <= '0;
            changed_reg <= 1'b0;
            cycle_reg   <= 1'b0;
        end else begin
            if (cmd.init) begin
                v_reg       <= '0;
                e_reg       <= '0;
                iter_reg    <= '0;
                k_reg       <= '0;
                changed_reg <= 1'b0;
                cycle_reg   <= 1'b0;
            end
            if (cmd.advance) begin
                if (e_last) begin
                    e_reg <= '0;
                    v_reg <= v_last ? '0 : v_reg + VIDX_W'(1);
                end else begin
                    e_reg <= e_reg + EIDX_W'(1);
                end
            end
            if (cmd.relax && update) changed_reg <= 1'b1;
            if (cmd.pass_next) begin
                iter_reg    <= iter_reg + VIDX_W'(1);
                changed_reg <= 1'b0;
            end
            if (cmd.set_cycle) cycle_reg <= 1'b1;
            if (cmd.out_next) k_reg <= k_reg + VIDX_W'(1);
        end
    end

    // Reach bits: all but the source's are cleared at the start of every job; all are cleared at its end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reach_reg <= '0;
        end else if (cmd.init) begin
            reach_reg <= source_ok ? (MAX_VERTICES'(1) << source_idx) : '0;
        end else if (cmd.relax && update) begin
            reach_reg[to_q] <= 1'b1;
        end else if (cmd.clear) begin
            reach_reg <= '0;
        end
    end

    // Distance memory: one write port, two registered read ports.
    logic signed [ACC_W-1:0] dist_mem [MAX_VERTICES];

    always_ff @(posedge aclk) begin
        if (cmd.init && source_ok) dist_mem[source_idx] <= '0;
        else if (cmd.relax && update) dist_mem[to_q] <= cand;
        if (cmd.dist_rd) begin
            dist_a_reg <= dist_mem[from_q];
            dist_b_reg <= dist_mem[to_q];
        end else if (cmd.out_rd) begin
            dist_a_reg <= dist_mem[k_reg];
        end
    end

    // Status to the controller.
    logic k_last, reach_out;
    assign k_last = (VCNT_W'(k_reg) + VCNT_W'(1)) == n_eff;

    always_comb begin
        status.last_in    = s_data.last_edge;
        status.skip       = !source_ok || (edge_total_reg == '0);
        status.edge_match = (from_q == v_reg) && (VCNT_W'(to_q) < n_eff)
                         && reach_reg[from_q];
        status.scan_end   = e_last && v_last;
        status.changed    = changed_reg;
        status.iter_last  = (VCNT_W'(iter_reg) + VCNT_W'(1)) == n_eff;
        status.k_last     = k_last;
    end

    // Result beat, held stable by the registers behind it.
    assign reach_out = reach_reg[k_reg] && !cycle_reg;

    always_comb begin
        m_data.vertex_index   = 6'(k_reg);
        m_data.distance       = reach_out ? 48'(dist_a_reg) : '0;
        m_data.reachable      = reach_out;
        m_data.negative_cycle = cycle_reg;
        m_data.edges_dropped  = dropped_reg;
        m_data.last_result    = k_last;
    end

endmodule

FILE: design/bellman_ford_shortest_paths.sv
// Loading takes one edge beat per cycle; then a setup state and up to vertex_count passes,
// each scanning every stored edge once per vertex (read and check states per edge visit,
// relax per matching edge, pass end per pass); then read and show states per result.
// Throughput: one job at a time; the edge memory port and the single relax adder set it.
// Reset: aresetn (synchronous, active low) clears edge count, flags, reach bits and
// sets vertex_count 1, source_vertex 0; no memory clearing pass is needed.
`timescale 1ns / 1ps

// Top level of the Bellman-Ford single-source shortest path block.
// It joins the controller state machine (bfsp_ctrl) to the datapath
// (bfsp_datapath). The controller only issues commands and reads status;
// all storage and arithmetic sit in the datapath.
//
// A job is a run of edge beats on the s_ channel ending with last_edge set.
// Edges with an endpoint at or above the vertex count, or beyond the edge
// memory capacity, are dropped and flagged in every result of the job.
// After the last edge the block stops accepting beats and relaxes edges
// pass after pass, vertex by vertex in ascending order, each vertex's
// outgoing edges in load order, until a pass makes no change. A change in
// the final allowed pass marks a reachable negative cycle.
// Then one result beat per vertex leaves on the m_ channel in ascending
// order, the last one flagged, and the block returns to loading.

module bellman_ford_shortest_paths import bfsp_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Edge input channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    // Result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data
);

    bfsp_cmd_t    cmd;
    bfsp_status_t status;

    // The controller decides, beat by beat, what the datapath does.
    bfsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the edge memory, the distance memory with its two
    // read ports, the reach bits, the scan counters and the relax adder.
    bfsp_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule

FILE: design/bfsp_checker.sv
// Port-level checker for the Bellman-Ford block and the bind that attaches
// it to bellman_ford_shortest_paths. Depends on bfsp_pkg.
`timescale 1ns / 1ps

module bfsp_checker import bfsp_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_beat_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // Loading and result output never overlap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result beat is pending");

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat changed while stalled");

    // The last edge of a job starts the computation and closes the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_edge) |=> !s_ready)
        else $error("input still ready after the last edge");

    // Unreachable vertices and negative-cycle jobs report distance zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (!m_data.reachable || m_data.negative_cycle))
            |-> (m_data.distance == '0 && !m_data.reachable))
        else $error("invalid distance reported");

endmodule

bind bellman_ford_shortest_paths bfsp_checker u_bfsp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: verif/testbench.sv
// Self-checking testbench for the Bellman-Ford shortest path block.
// Depends on bfsp_pkg (beat structs, register indexes) and the
// bellman_ford_shortest_paths top level; nothing else is read.
`timescale 1ns / 1ps

module testbench;
    import bfsp_pkg::*;

    localparam int MAX_V = 64;
    localparam int MAX_E = 256;
    localparam int WEIGHT_W = 32;

    // Minimum number of random edge beats after the directed and stress tests.
    localparam int RANDOM_ITEMS = 120;

    // A non-final edge beat is absorbed in the cycle it is accepted, so the
    // settle wait after the last result is enough before touching the registers.
    localparam int SETTLE_CYCLES = 8;

    // The slowest legal run comes from small graphs with negative cycles, one full
    // edge store on three vertices, a few large graphs with short edge lists, and a
    // long receiver hold. The watchdog allows ten times the expected length of that run.
    localparam longint WATCHDOG_NS = 16_000_000;

    // Edge record as the solver keeps it: endpoints and sign-extended weight.
    typedef struct {
        logic [5:0] tail;
        logic [5:0] head;
        longint     weight;
    } arc_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // Shadow copy of the block's registers and job state.
    logic [6:0] vcount_reg = VERTEX_COUNT_RESET;
    logic [5:0] src_reg = SOURCE_VERTEX_RESET;
    arc_t       loaded_arcs[$];
    bit         drop_seen = 1'b0;
    longint     best_dist[MAX_V];
    bit         reached[MAX_V];

    // Result beats predicted but not yet seen on the m_ channel, oldest first.
    out_beat_t  pending_results[$];

    // When set, both sides stop idling at random.
    bit steady = 1'b0;
    // A request to the result sink to hold m_ready low for this many cycles.
    int hold_request = 0;

    int errors = 0;
    int beats_sent = 0;
    int jobs_solved = 0;
    int result_beats = 0;
    int cycle_jobs = 0;
    int drop_jobs = 0;

    bellman_ford_shortest_paths #(
        .MAX_VERTICES(MAX_V),
        .MAX_EDGES   (MAX_E),
        .WEIGHT_BITS (WEIGHT_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Vertex count as the block applies it: zero behaves as one vertex and
    // anything above the capacity is clipped to it.
    function automatic int unsigned active_vertices();
        if (vcount_reg == 0) return 1;
        if (vcount_reg > MAX_V) return MAX_V;
        return 32'(vcount_reg);
    endfunction

    // Runs the relaxation passes over the loaded edges and queues one result
    // beat per vertex. Vertices are visited in ascending order and each
    // vertex's outgoing edges in load order, so a distance improved earlier
    // in a pass is already used later in the same pass. An edge whose head
    // is no longer below the vertex count (the count was lowered while the
    // job was loading) is skipped.
    function automatic void solve_paths(int unsigned n);
        bit        cycle;
        bit        changed;
        longint    cand;
        int        hd;
        out_beat_t res;
        cycle = 1'b0;
        for (int v = 0; v < MAX_V; v++) begin
            best_dist[v] = 0;
            reached[v] = 1'b0;
        end
        if (src_reg < n) begin
            reached[src_reg] = 1'b1;
            for (int round = 0; round < n; round++) begin
                changed = 1'b0;
                for (int v = 0; v < n; v++) begin
                    // Only an edge into v can make v reachable; during v's scan that is a
                    // self-loop, so an unreached vertex stays unreached for its whole scan.
                    if (!reached[v]) continue;
                    foreach (loaded_arcs[e]) begin
                        if (loaded_arcs[e].tail != v || loaded_arcs[e].head >= n) continue;
                        hd = loaded_arcs[e].head;
                        cand = best_dist[v] + loaded_arcs[e].weight;
                        if (!reached[hd] || best_dist[hd] > cand) begin
                            best_dist[hd] = cand;
                            reached[hd] = 1'b1;
                            changed = 1'b1;
                        end
                    end
                end
                if (!changed) break;
                // Still improving in the last allowed pass: negative cycle.
                if (round == n - 1) cycle = 1'b1;
            end
        end

        for (int k = 0; k < n; k++) begin
            res.vertex_index   = k[5:0];
            res.reachable      = reached[k] && !cycle;
            res.distance       = res.reachable ? best_dist[k][47:0] : '0;
            res.negative_cycle = cycle;
            res.edges_dropped  = drop_seen;
            res.last_result    = (k == n - 1);
            pending_results = {pending_results, res};
        end

        jobs_solved++;
        if (cycle) cycle_jobs++;
        if (drop_seen) drop_jobs++;
        loaded_arcs.delete();
        drop_seen = 1'b0;
    endfunction

    // Applies one accepted edge beat to the shadow state. The endpoints are
    // checked against the vertex count in force when the beat arrives.
    function automatic void absorb_edge(in_beat_t b);
        int unsigned n;
        arc_t        a;
        n = active_vertices();
        if (b.from_vertex >= n || b.to_vertex >= n || loaded_arcs.size() >= MAX_E) begin
            drop_seen = 1'b1;
        end else begin
            a.tail = b.from_vertex;
            a.head = b.to_vertex;
            a.weight = longint'($signed(b.edge_weight));
            loaded_arcs = {loaded_arcs, a};
        end
        if (b.last_edge) solve_paths(n);
    endfunction

    // ------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------

    // m_ready changes on the falling edge. A hold request from a test forces
    // it low for a counted stretch; otherwise it drops with a chance of 11 in
    // a hundred unless the test asked for a steady stretch.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 11);
            end
        end
    end

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Every accepted result beat is compared field by field with the oldest
    // prediction still waiting.
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            result_beats++;
            if (pending_results.size() == 0) begin
                $display("%0t ns: result beat with none expected, expected nothing, actual %p",
                         $time, m_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("vertex_index", want.vertex_index, m_data.vertex_index);
                compare_field("distance", want.distance, m_data.distance);
                compare_field("reachable", want.reachable, m_data.reachable);
                compare_field("negative_cycle", want.negative_cycle, m_data.negative_cycle);
                compare_field("edges_dropped", want.edges_dropped, m_data.edges_dropped);
                compare_field("last_result", want.last_result, m_data.last_result);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one edge beat. Inputs move on the falling edge; the handshake is
    // seen on the rising edge. The task returns right at the accepting edge,
    // so valid stays high into the next beat unless that beat idles first.
    task automatic send_edge(input logic [5:0] tail, input logic [5:0] head,
                             input logic signed [31:0] w, input bit last);
        in_beat_t b;
        b.from_vertex = tail;
        b.to_vertex   = head;
        b.edge_weight = w;
        b.last_edge   = last;
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_edge(b);
        beats_sent++;
    endtask

    // Stops offering beats and waits until every predicted result has come
    // back, then lets the block finish absorbing any trailing edge beat.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        if (idx == CFG_VERTEX_COUNT) vcount_reg = value[6:0];
        else src_reg = value[5:0];
        @(negedge aclk);
        cfg_write <= 1'b0;
    endtask

    // Registers are only rewritten once the block has gone quiet.
    task automatic configure(input int unsigned vc, input int unsigned src);
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, CFG_DATA_W'(vc));
        write_reg(CFG_SOURCE_VERTEX, CFG_DATA_W'(src));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves one vertex with source 0. A positive self-loop changes
    // nothing; an out-of-range edge is dropped, and a negative self-loop on
    // the lone vertex is a negative cycle found in the only pass.
    task automatic test_reset_defaults();
        send_edge(0, 0, 9, 1'b1);
        send_edge(3, 0, 1, 1'b0);
        send_edge(0, 0, -1, 1'b1);
    endtask

    // Extreme weights along a path, a cheaper detour, a zero self-loop and
    // two vertices the source cannot reach.
    task automatic test_basic_paths();
        configure(6, 1);
        send_edge(1, 2, 32'sh7FFF_FFFF, 1'b0);
        send_edge(2, 3, 32'sh8000_0000, 1'b0);
        send_edge(1, 3, 10, 1'b0);
        send_edge(3, 4, -7, 1'b0);
        send_edge(4, 4, 0, 1'b0);
        send_edge(0, 5, 1, 1'b1);
    endtask

    task automatic test_negative_cycle();
        configure(3, 0);
        send_edge(0, 1, 1, 1'b0);
        send_edge(1, 2, -3, 1'b0);
        send_edge(2, 1, 1, 1'b1);
    endtask

    // Tail out of range, head out of range, and then a job whose only edge
    // is dropped, so the solver runs with an empty edge list.
    task automatic test_dropped_edges();
        configure(4, 2);
        send_edge(5, 1, 3, 1'b0);
        send_edge(1, 63, 3, 1'b0);
        send_edge(2, 3, 4, 1'b1);
        send_edge(7, 0, 2, 1'b1);
    endtask

    // Source at 63 with four vertices: nothing is reachable, so the negative
    // cycle between 0 and 1 must not be reported. Bit 6 of the data is set to
    // show that it is ignored for this register.
    task automatic test_source_out_of_range();
        configure(4, 7'h7F);
        send_edge(0, 1, -5, 1'b0);
        send_edge(1, 0, -5, 1'b1);
    endtask

    // Vertex count zero acts as one; a count above capacity acts as the full
    // 64 vertices; the top vertex numbers are used as endpoints.
    task automatic test_vertex_count_limits();
        configure(0, 0);
        send_edge(0, 0, 3, 1'b1);
        configure(127, 62);
        send_edge(62, 63, -100, 1'b0);
        send_edge(63, 32, 7, 1'b1);
        configure(64, 33);
        send_edge(33, 0, -1, 1'b1);
    endtask

    // Edges loaded under eight vertices, then the count drops to six before
    // the final edge: the stored edge into vertex 6 must be ignored.
    task automatic test_count_lowered_mid_load();
        configure(8, 0);
        send_edge(0, 5, 1, 1'b0);
        send_edge(5, 6, 1, 1'b0);
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, CFG_DATA_W'(6));
        send_edge(0, 1, 2, 1'b1);
    endtask

    // Fills the edge store and runs past it, with no idling on either side.
    task automatic test_edge_store_full();
        logic signed [31:0] w;
        configure(3, $urandom_range(0, 2));
        steady = 1'b1;
        for (int i = 0; i < MAX_E + 3; i++) begin
            w = $signed($urandom_range(0, 1050)) - 50;
            send_edge(6'($urandom_range(0, 2)), 6'($urandom_range(0, 2)), w,
                      i == MAX_E + 2);
        end
        wait_idle();
        steady = 1'b0;
    endtask

    // The result sink holds off for a long stretch while three jobs are
    // offered back to back, so the block sits on its results and stalls the
    // edge channel. Afterwards the sender waits for every result.
    task automatic test_backpressure();
        configure(4, 0);
        hold_request = 1500;
        for (int j = 0; j < 3; j++) begin
            send_edge(0, 1, j + 1, 1'b0);
            send_edge(1, 2, 3, 1'b0);
            send_edge(2, 3, -1, 1'b0);
            send_edge(3, 0, 2, 1'b1);
        end
        wait_idle();
    endtask

    // Random jobs. Most edges stay inside the graph and many continue from
    // the previous head, so paths grow from the source; a few are noise with
    // arbitrary endpoints. Large graphs get short edge lists and only
    // non-negative weights to keep their pass count low. Registers change
    // before about a third of the jobs; other jobs follow straight on.
    task automatic test_random_graphs();
        int unsigned        n;
        int unsigned        roll;
        int unsigned        vc;
        int unsigned        edges_in_job;
        int                 sent;
        bit                 allow_neg;
        logic [5:0]         tail;
        logic [5:0]         head;
        logic signed [31:0] w;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 35) begin
                roll = $urandom_range(99);
                if (roll < 65) vc = $urandom_range(2, 10);
                else if (roll < 82) vc = $urandom_range(11, 24);
                else if (roll < 94) vc = $urandom_range(25, 64);
                else if (roll < 97) vc = $urandom_range(65, 127);
                else vc = $urandom_range(0, 1);
                n = (vc == 0) ? 1 : (vc > MAX_V ? MAX_V : vc);
                if ($urandom_range(99) < 85) configure(vc, $urandom_range(0, n - 1));
                else configure(vc, $urandom_range(0, 127));
            end
            n = active_vertices();
            allow_neg = (n <= 24);
            if (n <= 10) edges_in_job = $urandom_range(1, 16);
            else if (n <= 24) edges_in_job = $urandom_range(1, 12);
            else edges_in_job = $urandom_range(1, 8);

            head = (src_reg < n) ? src_reg : '0;
            for (int i = 0; i < edges_in_job; i++) begin
                roll = $urandom_range(99);
                if (roll < 8) begin
                    tail = 6'($urandom_range(0, 63));
                    head = 6'($urandom_range(0, 63));
                end else begin
                    tail = (roll < 50) ? head : 6'($urandom_range(0, n - 1));
                    head = 6'($urandom_range(0, n - 1));
                end
                roll = $urandom_range(99);
                if (!allow_neg) w = $urandom_range(0, 32'h7FFF_FFFF);
                else if (roll < 50) w = $urandom_range(0, 60);
                else if (roll < 80) w = $signed($urandom_range(0, 70)) - 30;
                else if (roll < 95) w = $urandom();
                else w = roll[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                send_edge(tail, head, w, i == edges_in_job - 1);
                sent++;
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_basic_paths();
        test_negative_cycle();
        test_dropped_edges();
        test_source_out_of_range();
        test_vertex_count_limits();
        test_count_lowered_mid_load();
        test_edge_store_full();
        test_backpressure();
        test_random_graphs();

        wait_idle();
        repeat (50) @(posedge aclk);

        $display("Covered %0d edge beats in %0d jobs, %0d result beats compared,",
                 beats_sent, jobs_solved, result_beats);
        $display("%0d jobs with a negative cycle and %0d with dropped edges.",
                 cycle_jobs, drop_jobs);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(WATCHDOG_NS);
        $display("Timed out with %0d results still expected", pending_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule
